[rtl/dhlt_pkg.sv]
// Shared types, constants and arithmetic helpers for the DH link transform.
`timescale 1ns / 1ps
`default_nettype none
package dhlt_pkg;

    typedef logic signed [33:0] t_cord;

    localparam int unsigned ATAN_ENTRIES = 30;
    localparam logic [29:0] RAD_TO_BAM = 30'd683565276;
    localparam t_cord CORDIC_GAIN_Q30 = 34'sd652032874;

    // register indexes
    localparam logic [2:0] REG_LINK_LENGTH = 3'd0;
    localparam logic [2:0] REG_LINK_TWIST  = 3'd1;
    localparam logic [2:0] REG_LINK_OFFS_D = 3'd2;
    localparam logic [2:0] REG_JOINT_ANGLE = 3'd3;
    localparam logic [2:0] REG_FREE_OFFSET = 3'd4;
    localparam logic [2:0] REG_CONVENTION  = 3'd5;
    localparam logic [2:0] REG_FREE_SELECT = 3'd6;

    // free parameter codes
    localparam logic [2:0] FREE_NONE  = 3'd0;
    localparam logic [2:0] FREE_R     = 3'd1;
    localparam logic [2:0] FREE_ALPHA = 3'd2;
    localparam logic [2:0] FREE_D     = 3'd3;
    localparam logic [2:0] FREE_THETA = 3'd4;

    localparam logic CONV_CLASSIC  = 1'b0;
    localparam logic CONV_MODIFIED = 1'b1;

    // arctangent of 2^-i in binary angle units
    function automatic t_cord atan_bam(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return t_cord'({2'b00, v});
    endfunction

    // Q2.30 CORDIC output to Q16 with rounding, clamp and quadrant sign
    function automatic logic signed [17:0] cord_q16(input t_cord v, input logic flip);
        t_cord t;
        logic signed [17:0] c;
        t = (v + 34'sd8192) >>> 14;
        if (t > 34'sd65536)
            c = 18'sd65536;
        else if (t < -34'sd65536)
            c = -18'sd65536;
        else
            c = t[17:0];
        return flip ? -c : c;
    endfunction

    // Q16 product back to Q16, floor of (p + half) / 2^16
    function automatic logic signed [36:0] mul_rnd(input logic signed [50:0] p);
        logic signed [50:0] t;
        t = (p + 51'sd32768) >>> 16;
        return t[36:0];
    endfunction

    function automatic logic signed [17:0] sat_rot(input logic signed [36:0] v);
        if (v > 37'sd65536)
            return 18'sd65536;
        else if (v < -37'sd65536)
            return -18'sd65536;
        return v[17:0];
    endfunction

    function automatic logic signed [31:0] sat_tr(input logic signed [36:0] v);
        if (v > 37'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -37'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

[rtl/dhlt_cordic.sv]
// Unrolled rotation-mode CORDIC, one iteration per register stage.
`timescale 1ns / 1ps
`default_nettype none
module dhlt_cordic #(
    parameter int STEPS = 16
) (
    input  wire                  i_clk,
    input  wire  [STEPS-1:0]     i_en,
    input  wire dhlt_pkg::t_cord i_z,
    input  wire                  i_flip,
    output dhlt_pkg::t_cord      o_x,
    output dhlt_pkg::t_cord      o_y,
    output logic                 o_flip
);

    dhlt_pkg::t_cord r_x [STEPS];
    dhlt_pkg::t_cord r_y [STEPS];
    dhlt_pkg::t_cord r_z [STEPS];
    logic            r_f [STEPS];

    genvar i;
    generate
        for (i = 0; i < STEPS; i++) begin : g_it
            dhlt_pkg::t_cord w_x, w_y, w_z;
            logic            w_f;
            if (i == 0) begin : g_first
                assign w_x = dhlt_pkg::CORDIC_GAIN_Q30;
                assign w_y = '0;
                assign w_z = i_z;
                assign w_f = i_flip;
            end else begin : g_rest
                assign w_x = r_x[i-1];
                assign w_y = r_y[i-1];
                assign w_z = r_z[i-1];
                assign w_f = r_f[i-1];
            end
            always_ff @(posedge i_clk) begin
                if (i_en[i]) begin
                    if (w_z >= 0) begin
                        r_x[i] <= w_x - (w_y >>> i);
                        r_y[i] <= w_y + (w_x >>> i);
                        r_z[i] <= w_z - dhlt_pkg::atan_bam(5'(i));
                    end else begin
                        r_x[i] <= w_x + (w_y >>> i);
                        r_y[i] <= w_y - (w_x >>> i);
                        r_z[i] <= w_z + dhlt_pkg::atan_bam(5'(i));
                    end
                    r_f[i] <= w_f;
                end
            end
        end
    endgenerate

    assign o_x    = r_x[STEPS-1];
    assign o_y    = r_y[STEPS-1];
    assign o_flip = r_f[STEPS-1];

endmodule
`default_nettype wire

[rtl/dh_link_transform_core.sv]
// Top level: DH link frame pipeline with APB-style register port.
//
//  channel   direction  handshake           payload
//  joint in  in         i_valid / o_stall   i_joint_value
//  frame out out        o_valid / i_stall   o_rot_00..o_rot_22, o_trans_x/y/z
//  config    in/out     psel/penable/pready paddr, pwdata, prdata
//
// One item per cycle sustained while i_stall is low; the pipeline is the
// unrolled CORDIC (one iteration per stage) plus input, angle
// multiply, reduction, rounding, product and output stages.
// Every stage holds a valid bit; a stall backs up only through full stages,
// so bubbles are squeezed out. Reset clears valids and sets config registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module dh_link_transform_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  signed [31:0] i_joint_value,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [17:0] o_rot_00,
    output logic signed [17:0] o_rot_01,
    output logic signed [17:0] o_rot_02,
    output logic signed [17:0] o_rot_10,
    output logic signed [17:0] o_rot_11,
    output logic signed [17:0] o_rot_12,
    output logic signed [17:0] o_rot_20,
    output logic signed [17:0] o_rot_21,
    output logic signed [17:0] o_rot_22,
    output logic signed [31:0] o_trans_x,
    output logic signed [31:0] o_trans_y,
    output logic signed [31:0] o_trans_z,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire        [4:0]   paddr,
    input  wire        [31:0]  pwdata,
    output logic       [31:0]  prdata,
    output logic               pready
);

    localparam int NIT   = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
    localparam int S_C0  = 3;
    localparam int S_RND = S_C0 + NIT;
    localparam int S_PRD = S_RND + 1;
    localparam int NST   = S_PRD + 2;

    // ---------------- configuration ----------------
    logic signed [31:0] r_link_length, r_link_twist, r_link_offs_d, r_joint_angle;
    logic signed [31:0] r_free_offset;
    logic               r_convention;
    logic        [2:0]  r_free_select;
    logic        [2:0]  w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_length <= '0;
            r_link_twist  <= '0;
            r_link_offs_d <= '0;
            r_joint_angle <= '0;
            r_free_offset <= '0;
            r_convention  <= dhlt_pkg::CONV_MODIFIED;
            r_free_select <= dhlt_pkg::FREE_NONE;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                dhlt_pkg::REG_LINK_LENGTH: r_link_length <= pwdata;
                dhlt_pkg::REG_LINK_TWIST:  r_link_twist  <= pwdata;
                dhlt_pkg::REG_LINK_OFFS_D: r_link_offs_d <= pwdata;
                dhlt_pkg::REG_JOINT_ANGLE: r_joint_angle <= pwdata;
                dhlt_pkg::REG_FREE_OFFSET: r_free_offset <= pwdata;
                dhlt_pkg::REG_CONVENTION:  r_convention  <= pwdata[0];
                dhlt_pkg::REG_FREE_SELECT: r_free_select <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            dhlt_pkg::REG_LINK_LENGTH: prdata = r_link_length;
            dhlt_pkg::REG_LINK_TWIST:  prdata = r_link_twist;
            dhlt_pkg::REG_LINK_OFFS_D: prdata = r_link_offs_d;
            dhlt_pkg::REG_JOINT_ANGLE: prdata = r_joint_angle;
            dhlt_pkg::REG_FREE_OFFSET: prdata = r_free_offset;
            dhlt_pkg::REG_CONVENTION:  prdata = {31'd0, r_convention};
            dhlt_pkg::REG_FREE_SELECT: prdata = {29'd0, r_free_select};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;

    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || !i_stall;
        for (int k = NST - 2; k >= 0; k--)
            w_en[k] = !r_v[k] || w_en[k+1];
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0])
                r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++)
                if (w_en[k])
                    r_v[k] <= r_v[k-1];
        end
    end

    // ---------------- stage 0: free parameter substitution ----------------
    logic signed [32:0] w_q, n_r, n_al, n_d, n_th;
    logic signed [32:0] r_th0, r_al0;
    logic signed [32:0] r_rp [S_PRD+1];
    logic signed [32:0] r_dp [S_PRD+1];

    assign w_q = 33'(i_joint_value) + 33'(r_free_offset);

    always_comb begin
        n_r  = 33'(r_link_length);
        n_al = 33'(r_link_twist);
        n_d  = 33'(r_link_offs_d);
        n_th = 33'(r_joint_angle);
        case (r_free_select)
            dhlt_pkg::FREE_R:     n_r  = w_q;
            dhlt_pkg::FREE_ALPHA: n_al = w_q;
            dhlt_pkg::FREE_D:     n_d  = w_q;
            dhlt_pkg::FREE_THETA: n_th = w_q;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_th0    <= n_th;
            r_al0    <= n_al;
            r_rp[0]  <= n_r;
            r_dp[0]  <= n_d;
        end
        for (int k = 1; k <= S_PRD; k++)
            if (w_en[k]) begin
                r_rp[k] <= r_rp[k-1];
                r_dp[k] <= r_dp[k-1];
            end
    end

    // ---------------- stage 1: radians to binary angle ----------------
    logic signed [30:0] w_k;
    logic signed [63:0] w_pth, w_pal;
    logic        [47:0] r_pth, r_pal;

    assign w_k   = $signed({1'b0, dhlt_pkg::RAD_TO_BAM});
    assign w_pth = 64'(r_th0) * 64'(w_k);
    assign w_pal = 64'(r_al0) * 64'(w_k);

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_pth <= w_pth[47:0];
            r_pal <= w_pal[47:0];
        end
    end

    // ---------------- stage 2: reduction to +-pi/2 ----------------
    logic [31:0] w_bth, w_bal, w_tth, w_tal, w_zth, w_zal;
    dhlt_pkg::t_cord r_zth, r_zal;
    logic            r_fth, r_fal;

    assign w_bth = r_pth[47:16];
    assign w_bal = r_pal[47:16];
    assign w_tth = w_bth + 32'h4000_0000;
    assign w_tal = w_bal + 32'h4000_0000;
    assign w_zth = w_tth[31] ? w_bth + 32'h8000_0000 : w_bth;
    assign w_zal = w_tal[31] ? w_bal + 32'h8000_0000 : w_bal;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_zth <= dhlt_pkg::t_cord'(signed'(w_zth));
            r_zal <= dhlt_pkg::t_cord'(signed'(w_zal));
            r_fth <= w_tth[31];
            r_fal <= w_tal[31];
        end
    end

    // ---------------- CORDIC stages ----------------
    dhlt_pkg::t_cord w_xth, w_yth, w_xal, w_yal;
    logic            w_fth, w_fal;

    dhlt_cordic #(.STEPS(NIT)) u_cordic_th (
        .i_clk  (i_clk),
        .i_en   (w_en[S_C0 +: NIT]),
        .i_z    (r_zth),
        .i_flip (r_fth),
        .o_x    (w_xth),
        .o_y    (w_yth),
        .o_flip (w_fth)
    );

    dhlt_cordic #(.STEPS(NIT)) u_cordic_al (
        .i_clk  (i_clk),
        .i_en   (w_en[S_C0 +: NIT]),
        .i_z    (r_zal),
        .i_flip (r_fal),
        .o_x    (w_xal),
        .o_y    (w_yal),
        .o_flip (w_fal)
    );

    // ---------------- rounding stage ----------------
    logic signed [17:0] r_ct, r_st, r_ca, r_sa;

    always_ff @(posedge i_clk) begin
        if (w_en[S_RND]) begin
            r_ct <= dhlt_pkg::cord_q16(w_xth, w_fth);
            r_st <= dhlt_pkg::cord_q16(w_yth, w_fth);
            r_ca <= dhlt_pkg::cord_q16(w_xal, w_fal);
            r_sa <= dhlt_pkg::cord_q16(w_yal, w_fal);
        end
    end

    // ---------------- product stage ----------------
    logic signed [17:0] r_ct_p, r_st_p, r_ca_p, r_sa_p;
    logic signed [35:0] r_stca, r_stsa, r_ctca, r_ctsa;
    logic signed [50:0] r_rct, r_rst, r_dsa, r_dca;

    always_ff @(posedge i_clk) begin
        if (w_en[S_PRD]) begin
            r_ct_p <= r_ct;
            r_st_p <= r_st;
            r_ca_p <= r_ca;
            r_sa_p <= r_sa;
            r_stca <= r_st * r_ca;
            r_stsa <= r_st * r_sa;
            r_ctca <= r_ct * r_ca;
            r_ctsa <= r_ct * r_sa;
            r_rct  <= r_rp[S_RND] * r_ct;
            r_rst  <= r_rp[S_RND] * r_st;
            r_dsa  <= r_dp[S_RND] * r_sa;
            r_dca  <= r_dp[S_RND] * r_ca;
        end
    end

    // ---------------- output stage ----------------
    logic signed [36:0] w_stca, w_stsa, w_ctca, w_ctsa, w_rct, w_rst, w_dsa, w_dca;

    assign w_stca = dhlt_pkg::mul_rnd(51'(r_stca));
    assign w_stsa = dhlt_pkg::mul_rnd(51'(r_stsa));
    assign w_ctca = dhlt_pkg::mul_rnd(51'(r_ctca));
    assign w_ctsa = dhlt_pkg::mul_rnd(51'(r_ctsa));
    assign w_rct  = dhlt_pkg::mul_rnd(r_rct);
    assign w_rst  = dhlt_pkg::mul_rnd(r_rst);
    assign w_dsa  = dhlt_pkg::mul_rnd(r_dsa);
    assign w_dca  = dhlt_pkg::mul_rnd(r_dca);

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            o_rot_00 <= r_ct_p;
            o_rot_11 <= dhlt_pkg::sat_rot(w_ctca);
            o_rot_22 <= r_ca_p;
            if (r_convention == dhlt_pkg::CONV_CLASSIC) begin
                o_rot_01  <= dhlt_pkg::sat_rot(-w_stca);
                o_rot_02  <= dhlt_pkg::sat_rot(w_stsa);
                o_rot_10  <= r_st_p;
                o_rot_12  <= dhlt_pkg::sat_rot(-w_ctsa);
                o_rot_20  <= '0;
                o_rot_21  <= r_sa_p;
                o_trans_x <= dhlt_pkg::sat_tr(w_rct);
                o_trans_y <= dhlt_pkg::sat_tr(w_rst);
                o_trans_z <= dhlt_pkg::sat_tr(37'(r_dp[S_PRD]));
            end else begin
                o_rot_01  <= -r_st_p;
                o_rot_02  <= '0;
                o_rot_10  <= dhlt_pkg::sat_rot(w_stca);
                o_rot_12  <= -r_sa_p;
                o_rot_20  <= dhlt_pkg::sat_rot(w_stsa);
                o_rot_21  <= dhlt_pkg::sat_rot(w_ctsa);
                o_trans_x <= dhlt_pkg::sat_tr(37'(r_rp[S_PRD]));
                o_trans_y <= dhlt_pkg::sat_tr(-w_dsa);
                o_trans_z <= dhlt_pkg::sat_tr(w_dca);
            end
        end
    end

    // ---------------- assertions ----------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_v[0])
        else $error("input stalled with an empty first stage");

    a_classic_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_convention == dhlt_pkg::CONV_CLASSIC) |-> o_rot_20 == 18'sd0)
        else $error("classic frame with nonzero rot_20");

    a_modified_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_convention == dhlt_pkg::CONV_MODIFIED) |-> o_rot_02 == 18'sd0)
        else $error("modified frame with nonzero rot_02");

endmodule
`default_nettype wire
